FILE: rtl/positional_list_engine_core_macros.svh
// assertion macros used by the positional list engine core
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ple assertion failed");

// next-cycle implication, held off during reset
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ple assertion failed");

`endif

FILE: rtl/ple_pkg.sv
// package with sizes, codes and shared types of the positional list engine
package ple_pkg;
   localparam int CAPACITY = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 6;
   localparam int VAL_W    = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_POS = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // edit request from the control to the slot table
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [SLOT_W-1:0] pos_idx;
      logic [CNT_W-1:0]  count;
   } map_op_type;
endpackage

FILE: rtl/ple_ram.sv
// generic single-port ram with registered read
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/ple_slot_map.sv
// position-to-slot table, a permutation of ram slots shifted in parallel
module ple_slot_map import ple_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  map_op_type        op,
   input  logic [SLOT_W-1:0] rd_idx,
   output logic [SLOT_W-1:0] free_slot,
   output logic [SLOT_W-1:0] pos_slot,
   output logic [SLOT_W-1:0] rd_slot
);
   logic [SLOT_W-1:0] map_ff [CAPACITY];
   logic [SLOT_W-1:0] map_in [CAPACITY];
   logic [CNT_W-1:0]  pos6;

   // entries at and above count hold the unused slots
   assign free_slot = map_ff[op.count[SLOT_W-1:0]];
   assign pos_slot  = map_ff[op.pos_idx];
   assign rd_slot   = map_ff[rd_idx];
   assign pos6      = CNT_W'(op.pos_idx);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         map_in[i] = map_ff[i];
         if (op.ins) begin
            if (CNT_W'(i) == pos6) begin
               map_in[i] = free_slot;
            end else if (CNT_W'(i) > pos6 && CNT_W'(i) <= op.count && i > 0) begin
               map_in[i] = map_ff[(i + CAPACITY - 1) % CAPACITY];
            end
         end else if (op.del) begin
            if (CNT_W'(i) == op.count - 1'b1) begin
               map_in[i] = pos_slot;
            end else if (CNT_W'(i) >= pos6 && CNT_W'(i) < op.count - 1'b1) begin
               map_in[i] = map_ff[(i + 1) % CAPACITY];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (reset) begin
            map_ff[i] <= SLOT_W'(i);
         end else begin
            map_ff[i] <= map_in[i];
         end
      end
   end
endmodule

FILE: rtl/positional_list_engine_core.sv
// top level of the positional list engine: control, slot table and value ram
// insert, delete, bad commands, empty reads: result registered in the cycle after the transfer
// read-out: per element a ram read (S_RADDR) then a result load (S_RDATA), which
//   waits while the result is still held; set by the single ram port and its registered read
// one command at a time; next transfer taken once the last result is loaded and the result register is free
// synchronous reset empties the list and restores the slot table, no clearing pass
module positional_list_engine_core import ple_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // count[5:0], elem_value[37:6], elem_index[43:38], pad
   output logic [2:0]  rsp_tuser,   // status[1:0], has_value[2]
   output logic        rsp_tlast
);
`include "positional_list_engine_core_macros.svh"

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RADDR = 2'd1;
   localparam logic [1:0] S_RDATA = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;

   // result holding register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_has_ff, rsp_has_in;
   logic [VAL_W-1:0]  rsp_val_ff, rsp_val_in;
   logic [CNT_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [1:0]        cmd;
   logic [VAL_W-1:0]  value;
   logic [CNT_W-1:0]  position;
   logic              req_xfer, rsp_free;
   logic              ins_ok, del_ok;
   map_op_type        op;
   logic [SLOT_W-1:0] free_slot, pos_slot, rd_slot;
   logic              ram_we, ram_re;
   logic [SLOT_W-1:0] ram_addr;
   logic [VAL_W-1:0]  ram_rdata;
   logic [CNT_W-1:0]  next_idx;

   assign value    = req_tdata[31:0];
   assign position = req_tdata[37:32];
   assign cmd      = req_tuser;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_xfer   = req_tvalid && req_tready;

   // position checks; insert allows count+1, delete stops at count
   assign ins_ok = (cmd == CMD_INSERT) && (count_ff < CNT_W'(CAPACITY)) &&
                   (position != '0) && (position <= count_ff + 1'b1);
   assign del_ok = (cmd == CMD_DELETE) && (position != '0) && (position <= count_ff);

   assign op.ins     = req_xfer && ins_ok;
   assign op.del     = req_xfer && del_ok;
   assign op.pos_idx = SLOT_W'(position - 1'b1);
   assign op.count   = count_ff;

   ple_slot_map u_map (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .rd_idx    (rd_idx_ff),
      .free_slot (free_slot),
      .pos_slot  (pos_slot),
      .rd_slot   (rd_slot)
   );

   // new value goes to the slot that becomes live; read-out follows the table
   assign ram_we   = op.ins;
   assign ram_re   = (state_ff == S_RADDR);
   assign ram_addr = ram_we ? free_slot : rd_slot;

   ple_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (value),
      .rd_data (ram_rdata)
   );

   assign next_idx = CNT_W'(rd_idx_ff) + 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               rsp_has_in  = 1'b0;
               rsp_val_in  = '0;
               rsp_idx_in  = '0;
               rsp_last_in = 1'b1;
               if (cmd == CMD_READ && count_ff != '0) begin
                  rd_idx_in = '0;
                  state_in  = S_RADDR;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (op.ins) begin
                     count_in = count_ff + 1'b1;
                  end else if (op.del) begin
                     count_in = count_ff - 1'b1;
                  end
                  rsp_count_in = count_in;
                  if (cmd == CMD_INSERT && count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_status_in = ST_FULL;
                  end else if (ins_ok || del_ok || cmd == CMD_READ) begin
                     rsp_status_in = ST_OK;
                  end else begin
                     rsp_status_in = ST_BAD_POS;
                  end
               end
            end
         end
         S_RADDR: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            // ram output holds until the next read, so waiting here is safe
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = count_ff;
               rsp_has_in    = 1'b1;
               rsp_val_in    = ram_rdata;
               rsp_idx_in    = next_idx;
               rsp_last_in   = (next_idx == count_ff);
               if (next_idx == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in  = S_RADDR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_idx_ff, rsp_val_ff, rsp_count_ff};
   assign rsp_tuser  = {rsp_has_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   `PLE_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PLE_ASSERT_NEXT(a_raddr_to_rdata, clock, reset, state_ff == S_RADDR, state_ff == S_RDATA)
   `PLE_ASSERT_NOW(a_read_in_range, clock, reset, state_ff != S_IDLE,
      CNT_W'(rd_idx_ff) < count_ff)
endmodule

FILE: bench/tb_positional_list_engine_core.sv
// self-checking bench for the positional list engine core
`timescale 1ns / 100ps

module tb_positional_list_engine_core import ple_pkg::*;;

   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] CMD_BAD = 2'd3;   // unused command code

   // one predicted result
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  count;
      logic        has_value;
      logic [31:0] elem_value;
      logic [5:0]  elem_index;
      logic        last;
   } list_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // value[31:0], position[37:32], zero pad
   logic [1:0]  req_tuser;    // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // count[5:0], elem_value[37:6], elem_index[43:38], pad
   logic [2:0]  rsp_tuser;    // status[1:0], has_value[2]
   logic        rsp_tlast;

   // predictor state: shadow list and its length
   logic [31:0]  shadow_list [CAPACITY];
   int           shadow_count;
   list_rsp_type pending_rsp [$];

   bit          failed;
   bit          hold_off;        // long receiver stall request
   bit          no_idle;         // stretch with no gaps or stalls
   int          idle_cycles;

   positional_list_engine_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // work out the results of one command and queue them
   function automatic void predict_command(logic [1:0] cmd, logic [31:0] value,
                                           logic [5:0] position);
      list_rsp_type r;
      int           i;
      r = '0;
      r.last = 1'b1;
      case (cmd)
         CMD_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (position < 1 || position > shadow_count + 1) begin
               r.status = ST_BAD_POS;
            end else begin
               for (i = shadow_count; i >= position; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[position-1] = value;
               shadow_count++;
               r.status = ST_OK;
            end
            r.count = 6'(shadow_count);
            pending_rsp.push_back(r);
         end
         CMD_DELETE: begin
            if (position < 1 || position > shadow_count) begin
               r.status = ST_BAD_POS;
            end else begin
               for (i = position - 1; i + 1 < shadow_count; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               r.status = ST_OK;
            end
            r.count = 6'(shadow_count);
            pending_rsp.push_back(r);
         end
         CMD_READ: begin
            r.status = ST_OK;
            r.count  = 6'(shadow_count);
            if (shadow_count == 0) begin
               pending_rsp.push_back(r);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  r.has_value  = 1'b1;
                  r.elem_value = shadow_list[i];
                  r.elem_index = 6'(i + 1);
                  r.last       = (i + 1 == shadow_count);
                  pending_rsp.push_back(r);
               end
            end
         end
         default: begin
            r.status = ST_BAD_POS;
            r.count  = 6'(shadow_count);
            pending_rsp.push_back(r);
         end
      endcase
   endfunction

   // offer one command, wait for its transfer, then maybe leave a gap
   task automatic send_command(logic [1:0] cmd, logic [31:0] value, logic [5:0] position);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, position, value};
      do @(posedge clock); while (!req_tready);
      predict_command(cmd, value, position);
      @(negedge clock);
      if (!no_idle && idle_cycles == 0 && $urandom_range(0, 5) == 0)
         idle_cycles = $urandom_range(1, 8);
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_cycles) @(negedge clock);
         idle_cycles = 0;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // extremes of every field and every listed case
   task automatic test_directed();
      send_command(CMD_READ, 32'h0, 6'd0);            // empty read-out
      send_command(CMD_DELETE, 32'h0, 6'd1);          // delete from empty list
      send_command(CMD_INSERT, 32'h1234_5678, 6'd0);  // position zero
      send_command(CMD_INSERT, 32'h1234_5678, 6'd2);  // beyond count+1
      send_command(CMD_INSERT, 32'h8000_0000, 6'd1);
      send_command(CMD_INSERT, 32'h7fff_ffff, 6'd2);  // append at end
      send_command(CMD_INSERT, 32'hffff_ffff, 6'd1);  // insert at head
      send_command(CMD_INSERT, 32'h0, 6'd2);          // insert in middle
      send_command(CMD_BAD, 32'hffff_ffff, 6'd63);
      send_command(CMD_READ, 32'hffff_ffff, 6'd63);
      send_command(CMD_DELETE, 32'h0, 6'd0);
      send_command(CMD_DELETE, 32'h0, 6'd5);
      send_command(CMD_DELETE, 32'h0, 6'd4);          // delete last
      send_command(CMD_DELETE, 32'h0, 6'd1);          // delete first
      send_command(CMD_READ, 32'h0, 6'd0);
      drain_results();
   endtask

   // fill to capacity, hit the full case, read the whole list, probe the last positions, then empty it
   task automatic test_full_list();
      while (shadow_count < CAPACITY)
         send_command(CMD_INSERT, pick_value(), 6'($urandom_range(1, shadow_count + 1)));
      send_command(CMD_INSERT, 32'h5555_aaaa, 6'd1);
      send_command(CMD_INSERT, 32'haaaa_5555, 6'd63);
      send_command(CMD_READ, 32'h0, 6'd0);
      send_command(CMD_DELETE, 32'h0, 6'd33);
      send_command(CMD_DELETE, 32'h0, 6'd32);
      send_command(CMD_INSERT, 32'hdead_beef, 6'd33);  // beyond count+1 after the delete, refused
      drain_results();
      while (shadow_count > 0)
         send_command(CMD_DELETE, 32'h0, 6'($urandom_range(1, shadow_count)));
      drain_results();
   endtask

   // long receiver stall while the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1'b1;
      repeat (6) send_command(CMD_INSERT, $urandom, 6'd1);
      send_command(CMD_READ, 32'h0, 6'd0);
      repeat (4) send_command(CMD_INSERT, $urandom, 6'd1);
      drain_results();
   endtask

   // mostly valid positions, some out of range, some unknown commands
   task automatic test_random(int n);
      int          k;
      logic [1:0]  cmd;
      logic [5:0]  pos;
      for (k = 0; k < n; k++) begin
         no_idle = (k % 100) >= 80;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: cmd = CMD_INSERT;
            8, 9, 10, 11, 12, 13:   cmd = CMD_DELETE;
            14, 15:                 cmd = CMD_READ;
            16:                     cmd = CMD_BAD;
            default: cmd = (shadow_count > 20) ? CMD_DELETE : CMD_INSERT;
         endcase
         if ($urandom_range(0, 9) == 0)
            pos = 6'($urandom);
         else if (cmd == CMD_DELETE && shadow_count > 0)
            pos = 6'($urandom_range(1, shadow_count));
         else
            pos = 6'($urandom_range(1, shadow_count + 1));
         send_command(cmd, pick_value(), pos);
      end
      no_idle = 1'b0;
      drain_results();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_INSERT;
      shadow_count = 0;
      failed       = 1'b0;
      hold_off     = 1'b0;
      no_idle      = 1'b0;
      idle_cycles  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_list();
      test_backpressure();
      test_random(376);
      if (!failed)
         $display("tb_positional_list_engine_core: done, clean");
      else
         $display("tb_positional_list_engine_core: done, errors");
      $finish;
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int k;
      rsp_tready = 1'b0;
      k = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         k++;
         rsp_tready <= no_idle || ((k % 7) < 5 && $urandom_range(0, 3) != 0);
      end
   end

   // result checker: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer");
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[1:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[5:0] !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_tdata[5:0]);
               failed = 1'b1;
            end
            if (rsp_tuser[2] !== want.has_value) begin
               $error("has_value: expected %0d, got %0d", want.has_value, rsp_tuser[2]);
               failed = 1'b1;
            end
            if (rsp_tdata[37:6] !== want.elem_value) begin
               $error("elem_value: expected %h, got %h", want.elem_value, rsp_tdata[37:6]);
               failed = 1'b1;
            end
            if (rsp_tdata[43:38] !== want.elem_index) begin
               $error("elem_index: expected %0d, got %0d", want.elem_index,
                      rsp_tdata[43:38]);
               failed = 1'b1;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb_positional_list_engine_core: done, errors");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_slot_map.sv
rtl/positional_list_engine_core.sv
bench/tb_positional_list_engine_core.sv
